FILE: rtl/core/mos_pkg.sv
// mos_pkg: shared types, constants and helpers for the multioperation
// superposition block. No dependencies.
package mos_pkg;

	localparam int MAX_ARITY  = 4;
	localparam int NUM_COLS   = 4;
	localparam int NUM_ROWS   = 2 ** MAX_ARITY;
	localparam int TABLE_W    = 2 * NUM_ROWS;
	localparam int ARITY_W    = 3;
	localparam int CFG_IDX_W  = 1;

	typedef logic [1:0]           entry_t;
	typedef logic [ARITY_W-1:0]   arity_t;
	typedef logic [TABLE_W-1:0]   table_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam entry_t ENT_ZERO  = 2'd0;
	localparam entry_t ENT_ONE   = 2'd1;
	localparam entry_t ENT_BOTH  = 2'd2;
	localparam entry_t ENT_UNDEF = 2'd3;

	localparam cfg_idx_t REG_OUTER_ARITY = 1'd0;
	localparam cfg_idx_t REG_INNER_ARITY = 1'd1;

	localparam arity_t ARITY_RESET = 3'd2;
	localparam arity_t ARITY_MIN   = 3'd1;
	localparam arity_t ARITY_MAX   = arity_t'(MAX_ARITY);

	typedef struct packed {
		logic   valid;
		arity_t inner_arity;
	} merge_ctl_t;

	function automatic arity_t clamp_arity(arity_t a);
		arity_t r;
		if (a < ARITY_MIN)
			r = ARITY_MIN;
		else if (a > ARITY_MAX)
			r = ARITY_MAX;
		else
			r = a;
		return r;
	endfunction

endpackage

FILE: rtl/core/multioperation_superposition.sv
// multioperation_superposition: top level; input register, sixteen
// evaluation lanes and the merging output stage.
// Depends on mos_pkg, mos_lane, mos_merge.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  command   | start, busy            | outer_table, column_zero..three
//  result    | done (one-cycle strobe)| composed_table
//  config    | cfg_write              | cfg_index, cfg_data
//
// One transaction per cycle; each result passes through the input register
// and then the output register around the lane logic. busy stays low: the
// pipeline never holds off.
// Reset clears the arity registers to 2 and drops all valid flags.
// The receiver cannot stall; done is a single-cycle strobe.
module multioperation_superposition (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  mos_pkg::table_t      outer_table,
	input  mos_pkg::table_t      column_zero,
	input  mos_pkg::table_t      column_one,
	input  mos_pkg::table_t      column_two,
	input  mos_pkg::table_t      column_three,
	output logic                 done,
	output mos_pkg::table_t      composed_table,
	input  logic                 cfg_write,
	input  mos_pkg::cfg_idx_t    cfg_index,
	input  mos_pkg::arity_t      cfg_data
);
	import mos_pkg::*;

	arity_t     outer_arity_q, inner_arity_q;
	logic       accept;
	logic       valid_s1;
	table_t     outer_s1;
	table_t     col_s1 [NUM_COLS];
	arity_t     oa_s1, ia_s1;
	entry_t     lane_entry [NUM_ROWS];
	merge_ctl_t mctl;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_arity_q <= ARITY_RESET;
			inner_arity_q <= ARITY_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OUTER_ARITY: outer_arity_q <= cfg_data;
				REG_INNER_ARITY: inner_arity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			outer_s1  <= outer_table;
			col_s1[0] <= column_zero;
			col_s1[1] <= column_one;
			col_s1[2] <= column_two;
			col_s1[3] <= column_three;
			oa_s1     <= clamp_arity(outer_arity_q);
			ia_s1     <= clamp_arity(inner_arity_q);
		end
	end

	// lane p evaluates result pair p from pair p of every column
	for (genvar p = 0; p < NUM_ROWS; p++) begin : g_lane
		entry_t lane_args [NUM_COLS];
		for (genvar j = 0; j < NUM_COLS; j++) begin : g_arg
			assign lane_args[j] = col_s1[j][2*p +: 2];
		end
		mos_lane u_lane (
			.outer_table (outer_s1),
			.outer_arity (oa_s1),
			.args        (lane_args),
			.entry       (lane_entry[p])
		);
	end

	assign mctl.valid       = valid_s1;
	assign mctl.inner_arity = ia_s1;

	mos_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (mctl),
		.lane_entry     (lane_entry),
		.done           (done),
		.composed_table (composed_table)
	);

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted transaction produced no result");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without a matching transaction");

	a_unused_pairs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ia_s1 != ARITY_MAX |=> (composed_table >> (2 << $past(ia_s1))) == '0)
		else $error("pairs beyond inner arity not cleared");

endmodule

FILE: rtl/core/mos_lane.sv
// mos_lane: evaluates the outer table on one argument vector (one result
// entry). Pure combinational. Depends on mos_pkg.
module mos_lane (
	input  mos_pkg::table_t outer_table,
	input  mos_pkg::arity_t outer_arity,
	input  mos_pkg::entry_t args [mos_pkg::NUM_COLS],
	output mos_pkg::entry_t entry
);
	import mos_pkg::*;

	always_comb begin
		logic                          any_undef;
		logic                          seen0, seen1, seen2, seen3;
		logic                          match;
		logic [MAX_ARITY-1:0]          rr;
		logic [MAX_ARITY-1:0]          rows_m1;
		logic [MAX_ARITY-1:0]          pos;
		logic [ARITY_W-1:0]            sh;
		entry_t                        e;
		any_undef = 1'b0;
		seen0     = 1'b0;
		seen1     = 1'b0;
		seen2     = 1'b0;
		seen3     = 1'b0;
		rows_m1   = MAX_ARITY'((NUM_ROWS - 1) >> (MAX_ARITY - int'(outer_arity)));
		for (int j = 0; j < NUM_COLS; j++) begin
			if (arity_t'(j) < outer_arity && args[j] == ENT_UNDEF)
				any_undef = 1'b1;
		end
		for (int r = 0; r < NUM_ROWS; r++) begin
			rr    = MAX_ARITY'(r);
			match = (rr <= rows_m1);
			for (int j = 0; j < NUM_COLS; j++) begin
				if (arity_t'(j) < outer_arity) begin
					// argument j drives index bit (arity-1-j)
					sh = outer_arity - arity_t'(j) - 3'd1;
					if (args[j] != ENT_BOTH && args[j] != {1'b0, rr[sh[1:0]]})
						match = 1'b0;
				end
			end
			pos = rows_m1 - rr;
			e   = outer_table[2*pos +: 2];
			if (match) begin
				case (e)
					ENT_ZERO: seen0 = 1'b1;
					ENT_ONE:  seen1 = 1'b1;
					ENT_BOTH: seen2 = 1'b1;
					default:  seen3 = 1'b1;
				endcase
			end
		end
		if (any_undef || seen3)
			entry = ENT_UNDEF;
		else if (seen0 && !seen1 && !seen2)
			entry = ENT_ZERO;
		else if (seen1 && !seen0 && !seen2)
			entry = ENT_ONE;
		else
			entry = ENT_BOTH;
	end

endmodule

FILE: rtl/core/mos_merge.sv
// mos_merge: gathers the lane entries into the result table, clears pairs
// beyond the inner arity and registers the result. Depends on mos_pkg.
module mos_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  mos_pkg::merge_ctl_t ctl,
	input  mos_pkg::entry_t     lane_entry [mos_pkg::NUM_ROWS],
	output logic                done,
	output mos_pkg::table_t     composed_table
);
	import mos_pkg::*;

	table_t merged;
	logic   done_s2;
	table_t table_s2;

	always_comb begin
		merged = '0;
		for (int p = 0; p < NUM_ROWS; p++) begin
			if ((p >> ctl.inner_arity) == 0)
				merged[2*p +: 2] = lane_entry[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s2 <= 1'b0;
		else
			done_s2 <= ctl.valid;
	end

	always_ff @(posedge clk) begin
		if (ctl.valid)
			table_s2 <= merged;
	end

	assign done           = done_s2;
	assign composed_table = table_s2;

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for multioperation_superposition.
// Predicts every composed table from the command fields and the arity registers.
// Depends on mos_pkg and the multioperation_superposition RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mos_pkg::*;

	// Holds the arity registers and the tables still owed by the block
	class composition_scoreboard;
		arity_t outer_reg = ARITY_RESET;
		arity_t inner_reg = ARITY_RESET;
		table_t expected_tables[$];
		int errors = 0;
		int checked = 0;

		function void write_reg(cfg_idx_t idx, arity_t val);
			if (idx == REG_OUTER_ARITY)
				outer_reg = val;
			else if (idx == REG_INNER_ARITY)
				inner_reg = val;
		endfunction

		function int unsigned effective(arity_t a);
			if (a < ARITY_MIN)
				return ARITY_MIN;
			if (a > ARITY_MAX)
				return ARITY_MAX;
			return a;
		endfunction

		// One composed entry from the argument vector of one result row
		function entry_t outer_value(table_t outer, int unsigned n, entry_t args[NUM_COLS]);
			int unsigned rows;
			bit hit;
			bit got0, got1, got2, got3;
			entry_t e;
			rows = 1 << n;
			got0 = 0; got1 = 0; got2 = 0; got3 = 0;
			for (int j = 0; j < n; j++)
				if (args[j] == ENT_UNDEF)
					return ENT_UNDEF;
			for (int unsigned r = 0; r < rows; r++) begin
				hit = 1;
				for (int j = 0; j < n; j++)
					if (args[j] != ENT_BOTH && args[j] != entry_t'((r >> (n - 1 - j)) & 1))
						hit = 0;
				if (hit) begin
					e = outer[2 * (rows - 1 - r) +: 2];
					case (e)
						ENT_ZERO: got0 = 1;
						ENT_ONE:  got1 = 1;
						ENT_BOTH: got2 = 1;
						default:  got3 = 1;
					endcase
				end
			end
			if (got3)
				return ENT_UNDEF;
			if (got0 && !got1 && !got2)
				return ENT_ZERO;
			if (got1 && !got0 && !got2)
				return ENT_ONE;
			return ENT_BOTH;
		endfunction

		function table_t compose(table_t outer, table_t cols[NUM_COLS]);
			int unsigned n_out, n_in;
			entry_t args[NUM_COLS];
			table_t res;
			n_out = effective(outer_reg);
			n_in = effective(inner_reg);
			res = '0;
			for (int unsigned p = 0; p < (1 << n_in); p++) begin
				for (int j = 0; j < NUM_COLS; j++)
					args[j] = cols[j][2 * p +: 2];
				res[2 * p +: 2] = outer_value(outer, n_out, args);
			end
			return res;
		endfunction

		function void note_command(table_t outer, table_t c0, table_t c1, table_t c2,
				table_t c3);
			table_t cols[NUM_COLS];
			cols[0] = c0; cols[1] = c1; cols[2] = c2; cols[3] = c3;
			expected_tables = {expected_tables, compose(outer, cols)};
		endfunction

		function void check_result(table_t got);
			table_t want;
			if (expected_tables.size() == 0) begin
				$error("composed_table: unexpected result %h", got);
				errors++;
				return;
			end
			want = expected_tables.pop_front();
			checked++;
			if (got !== want) begin
				$error("composed_table mismatch: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	table_t  outer_table = '0;
	table_t  column_zero = '0;
	table_t  column_one = '0;
	table_t  column_two = '0;
	table_t  column_three = '0;
	logic    done;
	table_t  composed_table;
	logic    cfg_write = 1'b0;
	cfg_idx_t cfg_index = REG_OUTER_ARITY;
	arity_t  cfg_data = ARITY_RESET;

	composition_scoreboard board;
	int idle_pct = 0;
	int settings_seen = 0;

	multioperation_superposition i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.outer_table    (outer_table),
		.column_zero    (column_zero),
		.column_one     (column_one),
		.column_two     (column_two),
		.column_three   (column_three),
		.done           (done),
		.composed_table (composed_table),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Transactions are taken and results checked on the same edge the DUT sees
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_command(outer_table, column_zero, column_one, column_two,
					column_three);
			if (done)
				board.check_result(composed_table);
		end
	end

	task automatic send(table_t outer, table_t c0, table_t c1, table_t c2, table_t c3);
		start <= 1'b1;
		outer_table <= outer;
		column_zero <= c0;
		column_one <= c1;
		column_two <= c2;
		column_three <= c3;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (board.expected_tables.size() != 0 && guard < 200) begin
			@(posedge clk);
			guard++;
		end
		if (board.expected_tables.size() != 0) begin
			$error("composed_table: %0d results never arrived", board.expected_tables.size());
			board.errors++;
			board.expected_tables.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// Both registers in back-to-back cycles, write enable held across them
	task automatic set_arities(arity_t outer_a, arity_t inner_a);
		cfg_write <= 1'b1;
		cfg_index <= REG_OUTER_ARITY;
		cfg_data <= outer_a;
		board.write_reg(REG_OUTER_ARITY, outer_a);
		@(posedge clk);
		cfg_index <= REG_INNER_ARITY;
		cfg_data <= inner_a;
		board.write_reg(REG_INNER_ARITY, inner_a);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		settings_seen++;
	endtask

	// Per pair: mostly 0/1, with chosen percentages of both-values and undefined
	function automatic table_t biased_table(int unsigned pct_both, int unsigned pct_undef);
		table_t t;
		int unsigned v;
		for (int i = 0; i < NUM_ROWS; i++) begin
			v = $urandom_range(99);
			if (v < pct_undef)
				t[2 * i +: 2] = ENT_UNDEF;
			else if (v < pct_undef + pct_both)
				t[2 * i +: 2] = ENT_BOTH;
			else
				t[2 * i +: 2] = $urandom_range(1) ? ENT_ONE : ENT_ZERO;
		end
		return t;
	endfunction

	task automatic random_command();
		if ($urandom_range(9) < 2)
			send($urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send(biased_table(8, 3), biased_table(25, 3), biased_table(25, 3),
				biased_table(25, 3), biased_table(25, 3));
	endtask

	arity_t outer_plan[12] = '{1, 4, 1, 4, 3, 0, 7, 5, 2, 6, 3, 4};
	arity_t inner_plan[12] = '{1, 4, 4, 1, 2, 7, 0, 3, 6, 5, 3, 2};

	initial begin
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset arities (2, 2): corner tables
		send('0, '0, '0, '0, '0);
		send('1, '1, '1, '1, '1);
		send(32'h0000_001B, 32'h0000_001B, 32'h0000_004E, '0, '0);
		send(32'h0000_0000, 32'h0000_00AA, 32'h0000_00AA, '0, '0);
		send(32'h0000_0055, 32'h0000_00AA, 32'h0000_00AA, '0, '0);
		send(32'h0000_0011, 32'h0000_00AA, 32'h0000_00AA, '0, '0);
		send(32'h0000_0003, 32'h0000_00AA, 32'h0000_00AA, '0, '0);
		send(32'h0000_0005, 32'h0000_0000, 32'h0000_00AA, '0, '0);
		send(32'h0000_0000, 32'h0000_00C0, 32'h0000_0000, '0, '0);
		// unused columns and unused upper pairs carry undefined entries
		send(32'h0000_001B, 32'h0000_0044, 32'h0000_0011, '1, '1);
		send(32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FF00, '1, '1);
		send(32'hE4E4_E4E4, 32'h2727_2727, 32'h9C9C_9C9C, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
		wait_drained();

		// Widest setting: full tables with expansion
		set_arities(ARITY_MAX, ARITY_MAX);
		send(32'h5555_5555, '1 >> 1 & 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
			32'hAAAA_AAAA);
		send(32'h5555_5554, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
		send(32'hFFFF_FFFF, '0, '0, '0, '0);
		send(32'h1B1B_1B1B, 32'h00FF_00FF, 32'h0F0F_0F0F, 32'h3333_3333, 32'h5555_5555);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			set_arities(outer_plan[ph], inner_plan[ph]);
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 68;
				default: idle_pct = 30;
			endcase
			repeat (62) random_command();
			wait_drained();
		end

		$display("%0d compositions checked over %0d arity settings, including out-of-range values",
			board.checked, settings_seen + 1);
		$display("sender idling exercised at 0, 30 and 68 percent");
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#500us;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/mos_pkg.sv
rtl/core/mos_lane.sv
rtl/core/mos_merge.sv
rtl/core/multioperation_superposition.sv
tb/testbench.sv
